// File: rtl/u6502x_pkg.sv
// ----------------------------------------------------------------------------
// Undocumented 6502 op executor package
// Shared opcode codes, operation kinds and addressing modes.
// ----------------------------------------------------------------------------
package u6502x_pkg;

  typedef enum logic [3:0] {
    K_LAX, K_SAX, K_DCM, K_INS, K_ALR, K_ARR, K_ANC, K_SLO, K_SRE, K_RLA, K_RRA, K_NONE
  } kind_e;

  typedef enum logic [3:0] {
    M_ABS, M_ABSX, M_ABSY, M_ZP, M_ZPX, M_ZPY, M_INDX, M_INDY, M_IMM
  } mode_e;

  localparam logic [5:0] OP_POKE   = 6'd30;
  localparam logic [5:0] OP_PEEK   = 6'd31;
  localparam logic [5:0] OP_LDREG  = 6'd32;
  localparam logic [5:0] OP_LDFLAG = 6'd33;

  function automatic kind_e form_kind(input logic [5:0] op);
    kind_e k;
    case (op)
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4:                      k = K_LAX;
      6'd5, 6'd6, 6'd7, 6'd8:                            k = K_SAX;
      6'd9, 6'd10:                                       k = K_DCM;
      6'd11, 6'd12:                                      k = K_INS;
      6'd13, 6'd15:                                      k = K_ALR;
      6'd14:                                             k = K_ARR;
      6'd16:                                             k = K_ANC;
      6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23:   k = K_SLO;
      6'd24, 6'd25:                                      k = K_SRE;
      6'd26, 6'd27:                                      k = K_RLA;
      6'd28, 6'd29:                                      k = K_RRA;
      default:                                           k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic mode_e form_mode(input logic [5:0] op);
    mode_e m;
    case (op)
      6'd0, 6'd5, 6'd9, 6'd11, 6'd17, 6'd24, 6'd26, 6'd28: m = M_ABS;
      6'd18:                                              m = M_ABSX;
      6'd1, 6'd19:                                        m = M_ABSY;
      6'd2, 6'd6, 6'd10, 6'd12, 6'd20, 6'd25, 6'd27, 6'd29: m = M_ZP;
      6'd21:                                              m = M_ZPX;
      6'd3, 6'd7:                                         m = M_ZPY;
      6'd8, 6'd22:                                        m = M_INDX;
      6'd4, 6'd23:                                        m = M_INDY;
      default:                                            m = M_IMM;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/undocumented_6502_op_executor_unit.sv
// ----------------------------------------------------------------------------
// Undocumented 6502 op executor
// Runs undocumented 6502 instruction forms and host operations against
// internal registers and a byte memory.
// ----------------------------------------------------------------------------
// The input channel carries one opcode, operand and data byte per transaction.
// Each transaction yields exactly one output transaction reporting A, X, Y,
// flags, PC and, for a peek, the byte read.
// Work is done by a sequencer around one single-port memory with registered
// read data. Register, immediate and host operations and the zero-page or
// absolute stores need no read before execution; forms and peeks that read
// memory pass through a read state first. The indirect forms pass two pointer
// reads, one data read and, for the forms that write back, one write-back
// through the single memory port in turn; the indirect store has no data read.
// One item is processed at a time. A new item is accepted in the cycle after
// the previous result has been moved into the output register, and the block
// keeps working while a finished result waits for the receiver.
// While the receiver stalls the output register holds; once the next result
// is ready the block waits for the register to drain.
// Reset clears A, X, Y, flags and PC; memory contents are undefined until
// written.
module undocumented_6502_op_executor_unit #(
  parameter int MEM_DEPTH = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [5:0]  opcode_i,
  input  logic [15:0] operand_i,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  a_out_o,
  output logic [7:0]  x_out_o,
  output logic [7:0]  y_out_o,
  output logic [3:0]  flags_out_o,
  output logic [15:0] pc_out_o,
  output logic [7:0]  read_data_o
);

  localparam int AW = $clog2(MEM_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PTR0 = 3'd1;
  localparam logic [2:0] S_PTR1 = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_EXEC = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [5:0]  op_q;
  logic [15:0] arg_q, ea_q, ea_d;
  logic [7:0]  dat_q, plo_q;
  logic [7:0]  a_q, a_d, x_q, x_d, y_q, y_d, rd_d;
  logic [3:0]  f_q, f_d;
  logic [15:0] pc_q, pc_d;
  logic        ov_q;

  logic          we;
  logic [15:0]   maddr;
  logic [7:0]    wdata, rdata;
  u6502x_pkg::kind_e kind;
  u6502x_pkg::mode_e mode;

  assign kind = u6502x_pkg::form_kind(op_q);
  assign mode = u6502x_pkg::form_mode(op_q);

  u6502x_ram #(.Width(8), .Depth(MEM_DEPTH)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (maddr[AW-1:0]),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);

  logic [7:0] v, sub;
  logic [8:0] sum;
  logic       cin;

  always_comb begin
    state_d = state_q;
    ea_d = ea_q;
    a_d = a_q; x_d = x_q; y_d = y_q; f_d = f_q; pc_d = pc_q; rd_d = 8'h00;
    we = 1'b0; maddr = ea_q; wdata = 8'h00;
    v = 8'h00; sub = 8'h00; sum = 9'h000;
    cin = f_q[0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PTR0;
        end
      end
      S_PTR0: begin
        state_d = S_READ;
        case (mode)
          u6502x_pkg::M_ABS:  ea_d = arg_q;
          u6502x_pkg::M_ABSX: ea_d = arg_q + {8'h00, x_q};
          u6502x_pkg::M_ABSY: ea_d = arg_q + {8'h00, y_q};
          u6502x_pkg::M_ZP:   ea_d = {8'h00, arg_q[7:0]};
          u6502x_pkg::M_ZPX:  ea_d = {8'h00, arg_q[7:0] + x_q};
          u6502x_pkg::M_ZPY:  ea_d = {8'h00, arg_q[7:0] + y_q};
          u6502x_pkg::M_INDX: begin
            ea_d = {8'h00, arg_q[7:0] + x_q};
            state_d = S_PTR1;
          end
          u6502x_pkg::M_INDY: begin
            ea_d = {8'h00, arg_q[7:0]};
            state_d = S_PTR1;
          end
          default: ea_d = arg_q;
        endcase
        if (op_q >= u6502x_pkg::OP_POKE) begin
          ea_d = arg_q;
        end
        if (kind == u6502x_pkg::K_ALR || kind == u6502x_pkg::K_ARR ||
            kind == u6502x_pkg::K_ANC || kind == u6502x_pkg::K_SAX ||
            op_q == u6502x_pkg::OP_POKE || op_q == u6502x_pkg::OP_LDREG ||
            op_q == u6502x_pkg::OP_LDFLAG || (op_q > u6502x_pkg::OP_LDFLAG)) begin
          state_d = (mode == u6502x_pkg::M_INDX || mode == u6502x_pkg::M_INDY) &&
                    kind != u6502x_pkg::K_NONE ? S_PTR1 : S_EXEC;
        end
        if (kind == u6502x_pkg::K_NONE) begin
          state_d = (op_q == u6502x_pkg::OP_PEEK) ? S_READ : S_EXEC;
        end
      end
      S_PTR1: begin
        maddr = ea_q;
        ea_d = {8'h00, ea_q[7:0] + 8'd1};
        state_d = S_READ;
      end
      S_READ: begin
        maddr = ea_q;
        if (mode == u6502x_pkg::M_INDX || mode == u6502x_pkg::M_INDY) begin
          if (ov_q) begin
            ea_d = {rdata, plo_q};
            if (mode == u6502x_pkg::M_INDY) begin
              ea_d = {rdata, plo_q} + {8'h00, y_q};
            end
          end
        end
        state_d = S_EXEC;
        if ((mode == u6502x_pkg::M_INDX || mode == u6502x_pkg::M_INDY) &&
            kind != u6502x_pkg::K_NONE) begin
          if (!ov_q) begin
            state_d = S_READ;
          end else begin
            state_d = (kind == u6502x_pkg::K_SAX) ? S_EXEC : S_DONE;
          end
        end
      end
      S_DONE: begin
        maddr = ea_q;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
        maddr = ea_q;
        case (kind)
          u6502x_pkg::K_LAX: begin
            a_d = rdata; x_d = rdata; f_d[3] = rdata[7]; f_d[1] = (rdata == 8'h00);
          end
          u6502x_pkg::K_SAX: begin
            we = 1'b1; wdata = a_q & x_q;
          end
          u6502x_pkg::K_DCM: begin
            v = rdata - 8'd1; we = 1'b1; wdata = v;
            sub = a_q - v;
            f_d[0] = (a_q >= v); f_d[3] = sub[7]; f_d[1] = (sub == 8'h00);
          end
          u6502x_pkg::K_INS: begin
            v = rdata + 8'd1; we = 1'b1; wdata = v;
            sum = {1'b0, a_q} + {1'b0, ~v} + {8'h00, cin};
            f_d[0] = sum[8];
            f_d[2] = (a_q[7] ^ sum[7]) & (~v[7] ^ sum[7]);
            a_d = sum[7:0]; f_d[3] = sum[7]; f_d[1] = (sum[7:0] == 8'h00);
          end
          u6502x_pkg::K_ALR: begin
            v = a_q & arg_q[7:0];
            f_d[0] = v[0]; a_d = {1'b0, v[7:1]};
            f_d[3] = 1'b0; f_d[1] = (v[7:1] == 7'h00);
          end
          u6502x_pkg::K_ARR: begin
            v = a_q & arg_q[7:0];
            a_d = {cin, v[7:1]};
            f_d[0] = a_d[6]; f_d[2] = a_d[6] ^ a_d[5];
            f_d[3] = a_d[7]; f_d[1] = (a_d == 8'h00);
          end
          u6502x_pkg::K_ANC: begin
            v = a_q & arg_q[7:0];
            a_d = v; f_d[0] = v[7]; f_d[3] = v[7]; f_d[1] = (v == 8'h00);
          end
          u6502x_pkg::K_SLO: begin
            v = {rdata[6:0], 1'b0}; we = 1'b1; wdata = v;
            f_d[0] = rdata[7]; a_d = a_q | v;
            f_d[3] = a_d[7]; f_d[1] = (a_d == 8'h00);
          end
          u6502x_pkg::K_SRE: begin
            v = {1'b0, rdata[7:1]}; we = 1'b1; wdata = v;
            f_d[0] = rdata[0]; a_d = a_q ^ v;
            f_d[3] = a_d[7]; f_d[1] = (a_d == 8'h00);
          end
          u6502x_pkg::K_RLA: begin
            v = {rdata[6:0], cin}; we = 1'b1; wdata = v;
            f_d[0] = rdata[7]; a_d = a_q & v;
            f_d[3] = a_d[7]; f_d[1] = (a_d == 8'h00);
          end
          u6502x_pkg::K_RRA: begin
            v = {cin, rdata[7:1]}; we = 1'b1; wdata = v;
            sum = {1'b0, a_q} + {1'b0, v} + {8'h00, rdata[0]};
            f_d[0] = sum[8];
            f_d[2] = (a_q[7] ^ sum[7]) & (v[7] ^ sum[7]);
            a_d = sum[7:0]; f_d[3] = sum[7]; f_d[1] = (sum[7:0] == 8'h00);
          end
          default: begin
            case (op_q)
              u6502x_pkg::OP_POKE: begin
                we = 1'b1; wdata = dat_q;
              end
              u6502x_pkg::OP_PEEK: rd_d = rdata;
              u6502x_pkg::OP_LDREG: begin
                a_d = dat_q; x_d = arg_q[7:0]; y_d = arg_q[15:8];
              end
              u6502x_pkg::OP_LDFLAG: begin
                f_d = {dat_q[7], dat_q[6], dat_q[1], dat_q[0]}; pc_d = arg_q;
              end
              default: ;
            endcase
          end
        endcase
        if (kind != u6502x_pkg::K_NONE) begin
          pc_d = pc_q + ((mode == u6502x_pkg::M_ABS || mode == u6502x_pkg::M_ABSX ||
                          mode == u6502x_pkg::M_ABSY) ? 16'd3 : 16'd2);
        end
        if (out_valid_o && !out_ready_i) begin
          state_d = S_EXEC;
          we = 1'b0;
          a_d = a_q; x_d = x_q; y_d = y_q; f_d = f_q; pc_d = pc_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      a_q <= 8'h00; x_q <= 8'h00; y_q <= 8'h00; f_q <= 4'h0; pc_q <= 16'h0000;
      out_valid_o <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      a_q <= a_d; x_q <= x_d; y_q <= y_d; f_q <= f_d; pc_q <= pc_d;
      if (state_q == S_PTR1) begin
        ov_q <= 1'b0;
      end else if (state_q == S_READ) begin
        ov_q <= ~ov_q;
      end else if (state_q == S_IDLE) begin
        ov_q <= 1'b0;
      end
      if (state_q == S_EXEC && state_d == S_IDLE) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ea_q <= ea_d;
    if (state_q == S_IDLE && in_valid_i) begin
      op_q <= opcode_i; arg_q <= operand_i; dat_q <= data_i;
    end
    if (state_q == S_READ && !ov_q) begin
      plo_q <= rdata;
    end
    if (state_q == S_EXEC && state_d == S_IDLE) begin
      a_out_o <= a_d; x_out_o <= x_d; y_out_o <= y_d;
      flags_out_o <= f_d; pc_out_o <= pc_d; read_data_o <= rd_d;
    end
  end

endmodule

// File: rtl/u6502x_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, written when enabled and always read; read data is registered.
// ----------------------------------------------------------------------------
module u6502x_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Undocumented 6502 op executor testbench
// Drives directed and random instruction and host transactions through the
// executor while a local copy of the registers and memory works out each
// expected result. Every result is compared field by field, in order. The
// sender works in bursts and the receiver stalls, once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [5:0]  op;
    logic [15:0] arg;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [3:0]  flags;
    logic [15:0] pc;
    logic [7:0]  rdata;
  } regs_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [5:0]  opcode_i = '0;
  logic [15:0] operand_i = '0;
  logic [7:0]  data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  a_out_o, x_out_o, y_out_o, read_data_o;
  logic [3:0]  flags_out_o;
  logic [15:0] pc_out_o;

  cmd_t  pending_cmds[$];
  regs_t expected_regs[$];

  logic [7:0]  m_a, m_x, m_y;
  logic [3:0]  m_flags;
  logic [15:0] m_pc;
  logic [7:0]  m_mem [0:65535];
  bit          m_written [0:65535];

  int mismatches = 0;
  int cycle_cnt = 0;
  int gap_cnt = 0;
  int burst_cnt = 0;
  int hold_cnt = 0;
  bit long_hold_done = 1'b0;

  undocumented_6502_op_executor_unit uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic u6502x_pkg::kind_e op_kind(input logic [5:0] op);
    case (op)
      0, 1, 2, 3, 4:              return u6502x_pkg::K_LAX;
      5, 6, 7, 8:                 return u6502x_pkg::K_SAX;
      9, 10:                      return u6502x_pkg::K_DCM;
      11, 12:                     return u6502x_pkg::K_INS;
      13, 15:                     return u6502x_pkg::K_ALR;
      14:                         return u6502x_pkg::K_ARR;
      16:                         return u6502x_pkg::K_ANC;
      17, 18, 19, 20, 21, 22, 23: return u6502x_pkg::K_SLO;
      24, 25:                     return u6502x_pkg::K_SRE;
      26, 27:                     return u6502x_pkg::K_RLA;
      28, 29:                     return u6502x_pkg::K_RRA;
      default:                    return u6502x_pkg::K_NONE;
    endcase
  endfunction

  function automatic u6502x_pkg::mode_e op_mode(input logic [5:0] op);
    case (op)
      0, 5, 9, 11, 17, 24, 26, 28:  return u6502x_pkg::M_ABS;
      18:                           return u6502x_pkg::M_ABSX;
      1, 19:                        return u6502x_pkg::M_ABSY;
      2, 6, 10, 12, 20, 25, 27, 29: return u6502x_pkg::M_ZP;
      21:                           return u6502x_pkg::M_ZPX;
      3, 7:                         return u6502x_pkg::M_ZPY;
      8, 22:                        return u6502x_pkg::M_INDX;
      4, 23:                        return u6502x_pkg::M_INDY;
      default:                      return u6502x_pkg::M_IMM;
    endcase
  endfunction

  function automatic logic [15:0] ptr_at(input logic [7:0] zp);
    return {m_mem[8'(zp + 8'd1)], m_mem[zp]};
  endfunction

  function automatic logic [15:0] eff_addr(input u6502x_pkg::mode_e md,
                                           input logic [15:0] arg);
    case (md)
      u6502x_pkg::M_ABS:  return arg;
      u6502x_pkg::M_ABSX: return arg + 16'(m_x);
      u6502x_pkg::M_ABSY: return arg + 16'(m_y);
      u6502x_pkg::M_ZP:   return {8'h00, arg[7:0]};
      u6502x_pkg::M_ZPX:  return {8'h00, 8'(arg[7:0] + m_x)};
      u6502x_pkg::M_ZPY:  return {8'h00, 8'(arg[7:0] + m_y)};
      u6502x_pkg::M_INDX: return ptr_at(8'(arg[7:0] + m_x));
      u6502x_pkg::M_INDY: return ptr_at(arg[7:0]) + 16'(m_y);
      default:            return 16'h0000;
    endcase
  endfunction

  function automatic void put_nz(input logic [7:0] v);
    m_flags[3] = v[7];
    m_flags[1] = (v == 8'h00);
  endfunction

  function automatic void add_acc(input logic [7:0] v, input logic cin);
    logic [8:0] sum;
    sum = {1'b0, m_a} + {1'b0, v} + 9'(cin);
    m_flags[0] = sum[8];
    m_flags[2] = (m_a[7] ^ sum[7]) & (v[7] ^ sum[7]);
    m_a = sum[7:0];
    put_nz(m_a);
  endfunction

  function automatic void store(input logic [15:0] addr, input logic [7:0] v);
    m_mem[addr] = v;
    m_written[addr] = 1'b1;
  endfunction

  // Applies one transaction to the local state and queues its result.
  task automatic run_step(input cmd_t c);
    u6502x_pkg::kind_e k;
    u6502x_pkg::mode_e md;
    logic [15:0]       ea;
    logic              cin;
    logic [7:0]        v;
    regs_t             r;
    k = op_kind(c.op);
    md = op_mode(c.op);
    cin = m_flags[0];
    r.rdata = 8'h00;
    if (k != u6502x_pkg::K_NONE) begin
      ea = eff_addr(md, c.arg);
      case (k)
        u6502x_pkg::K_LAX: begin
          v = m_mem[ea]; m_a = v; m_x = v; put_nz(v);
        end
        u6502x_pkg::K_SAX: store(ea, m_a & m_x);
        u6502x_pkg::K_DCM: begin
          v = m_mem[ea] - 8'd1; store(ea, v);
          m_flags[0] = (m_a >= v); put_nz(m_a - v);
        end
        u6502x_pkg::K_INS: begin
          v = m_mem[ea] + 8'd1; store(ea, v); add_acc(~v, cin);
        end
        u6502x_pkg::K_ALR: begin
          m_a = m_a & c.arg[7:0]; m_flags[0] = m_a[0]; m_a = m_a >> 1; put_nz(m_a);
        end
        u6502x_pkg::K_ARR: begin
          m_a = m_a & c.arg[7:0]; m_a = {cin, m_a[7:1]};
          m_flags[0] = m_a[6]; m_flags[2] = m_a[6] ^ m_a[5]; put_nz(m_a);
        end
        u6502x_pkg::K_ANC: begin
          m_a = m_a & c.arg[7:0]; m_flags[0] = m_a[7]; put_nz(m_a);
        end
        u6502x_pkg::K_SLO: begin
          v = m_mem[ea]; m_flags[0] = v[7]; v = v << 1; store(ea, v);
          m_a = m_a | v; put_nz(m_a);
        end
        u6502x_pkg::K_SRE: begin
          v = m_mem[ea]; m_flags[0] = v[0]; v = v >> 1; store(ea, v);
          m_a = m_a ^ v; put_nz(m_a);
        end
        u6502x_pkg::K_RLA: begin
          v = m_mem[ea]; m_flags[0] = v[7]; v = {v[6:0], cin}; store(ea, v);
          m_a = m_a & v; put_nz(m_a);
        end
        default: begin
          v = m_mem[ea]; m_flags[0] = v[0]; v = {cin, v[7:1]}; store(ea, v);
          add_acc(v, m_flags[0]);
        end
      endcase
      m_pc = m_pc + ((md == u6502x_pkg::M_ABS || md == u6502x_pkg::M_ABSX ||
                      md == u6502x_pkg::M_ABSY) ? 16'd3 : 16'd2);
    end else if (c.op == u6502x_pkg::OP_POKE) begin
      store(c.arg, c.data);
    end else if (c.op == u6502x_pkg::OP_PEEK) begin
      r.rdata = m_mem[c.arg];
    end else if (c.op == u6502x_pkg::OP_LDREG) begin
      m_a = c.data; m_x = c.arg[7:0]; m_y = c.arg[15:8];
    end else if (c.op == u6502x_pkg::OP_LDFLAG) begin
      m_flags = {c.data[7], c.data[6], c.data[1], c.data[0]};
      m_pc = c.arg;
    end
    r.a = m_a; r.x = m_x; r.y = m_y; r.flags = m_flags; r.pc = m_pc;
    pending_cmds.push_back(c);
    expected_regs.push_back(r);
  endtask

  task automatic fill_if_blank(input logic [15:0] addr);
    cmd_t c;
    if (!m_written[addr]) begin
      c.op = u6502x_pkg::OP_POKE; c.arg = addr; c.data = 8'($urandom);
      run_step(c);
    end
  endtask

  // Queues a transaction, first poking any byte it would read that was never written.
  task automatic send(input logic [5:0] op, input logic [15:0] arg, input logic [7:0] data);
    cmd_t              c;
    u6502x_pkg::kind_e k;
    u6502x_pkg::mode_e md;
    k = op_kind(op);
    md = op_mode(op);
    if (md == u6502x_pkg::M_INDX) begin
      fill_if_blank({8'h00, 8'(arg[7:0] + m_x)});
      fill_if_blank({8'h00, 8'(arg[7:0] + m_x + 8'd1)});
    end else if (md == u6502x_pkg::M_INDY) begin
      fill_if_blank({8'h00, arg[7:0]});
      fill_if_blank({8'h00, 8'(arg[7:0] + 8'd1)});
    end
    if (k != u6502x_pkg::K_NONE && k != u6502x_pkg::K_SAX && md != u6502x_pkg::M_IMM)
      fill_if_blank(eff_addr(md, arg));
    if (op == u6502x_pkg::OP_PEEK) fill_if_blank(arg);
    c.op = op; c.arg = arg; c.data = data;
    run_step(c);
  endtask

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 5))
      0, 1:    return 16'($urandom_range(0, 255));
      2:       return 16'($urandom_range(16'h01F0, 16'h0210));
      3:       return 16'($urandom_range(16'hFF00, 16'hFFFF));
      4:       return 16'($urandom_range(16'h4000, 16'h401F));
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    cmd_t c;
    logic nxt_valid;
    if (rst_ni) begin
      nxt_valid = in_valid_i;
      if (!in_valid_i || in_ready_o) begin
        nxt_valid = 1'b0;
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          opcode_i <= c.op;
          operand_i <= c.arg;
          data_i <= c.data;
          nxt_valid = 1'b1;
          if (burst_cnt <= 1) begin
            burst_cnt <= $urandom_range(1, 30);
            gap_cnt <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_cnt <= burst_cnt - 1;
          end
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  always @(posedge clk_i) begin
    logic nxt_ready;
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      if (!long_hold_done && cycle_cnt == 3000) begin
        hold_cnt <= 400;
        long_hold_done <= 1'b1;
        nxt_ready = 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        nxt_ready = 1'b0;
      end else begin
        case ((cycle_cnt / 256) % 4)
          0:       nxt_ready = 1'b1;
          1:       nxt_ready = ($urandom_range(0, 1) == 1);
          2:       nxt_ready = ($urandom_range(0, 4) == 0);
          default: nxt_ready = (cycle_cnt % 7) < 4;
        endcase
      end
      out_ready_i <= nxt_ready;
    end
  end

  always @(posedge clk_i) begin
    regs_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_regs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: a=%h pc=%h",
                                       a_out_o, pc_out_o);
      end else begin
        e = expected_regs.pop_front();
        if (a_out_o !== e.a || x_out_o !== e.x || y_out_o !== e.y ||
            flags_out_o !== e.flags || pc_out_o !== e.pc || read_data_o !== e.rdata) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected a=%h x=%h y=%h f=%h pc=%h rd=%h,",
                     e.a, e.x, e.y, e.flags, e.pc, e.rdata);
            $display("          got      a=%h x=%h y=%h f=%h pc=%h rd=%h",
                     a_out_o, x_out_o, y_out_o, flags_out_o, pc_out_o, read_data_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt > 600000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [5:0] op;
    m_a = 0; m_x = 0; m_y = 0; m_flags = 0; m_pc = 0;
    for (int i = 0; i < 65536; i++) begin
      m_mem[i] = 8'h00;
      m_written[i] = 1'b0;
    end

    // Directed part: pointer wrap, index wraps, flag corner cases, host ops.
    send(u6502x_pkg::OP_POKE, 16'h00FF, 8'hFF);
    send(u6502x_pkg::OP_POKE, 16'h0000, 8'hFF);
    send(u6502x_pkg::OP_LDREG, 16'hFFFF, 8'h00);
    send(4, 16'h00FF, 8'h00);
    send(u6502x_pkg::OP_PEEK, 16'hFFFE, 8'h00);
    send(18, 16'hFFFF, 8'h00);
    send(21, 16'h0080, 8'h00);
    send(22, 16'h0001, 8'h00);
    send(u6502x_pkg::OP_LDFLAG, 16'hFFFF, 8'hFF);
    send(14, 16'h00FF, 8'h00);
    send(u6502x_pkg::OP_LDREG, 16'h0000, 8'hFF);
    send(14, 16'h00C0, 8'h00);
    send(16, 16'h0080, 8'h00);
    send(15, 16'h0001, 8'h00);
    send(13, 16'h00FF, 8'h00);
    send(u6502x_pkg::OP_POKE, 16'h0010, 8'hFF);
    send(12, 16'h0010, 8'h00);
    send(u6502x_pkg::OP_POKE, 16'h0011, 8'h00);
    send(10, 16'h0011, 8'h00);
    send(28, 16'h0011, 8'h00);
    send(8, 16'h0000, 8'h00);
    send(63, 16'hFFFF, 8'hFF);
    send(u6502x_pkg::OP_LDFLAG, 16'h0000, 8'h00);
    send(u6502x_pkg::OP_PEEK, 16'h0000, 8'h00);

    for (int n = 0; n < 1000; n++) begin
      case ($urandom_range(0, 19))
        0:       op = u6502x_pkg::OP_POKE;
        1:       op = u6502x_pkg::OP_PEEK;
        2:       op = u6502x_pkg::OP_LDREG;
        3:       op = u6502x_pkg::OP_LDFLAG;
        4:       op = 6'($urandom_range(34, 63));
        default: op = 6'($urandom_range(0, 29));
      endcase
      send(op,
           (op == u6502x_pkg::OP_LDREG || op == u6502x_pkg::OP_LDFLAG) ?
             16'($urandom) : pick_addr(),
           8'($urandom));
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_cmds.size() == 0 && !in_valid_i && expected_regs.size() == 0);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && expected_regs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
